// ===== hw/rtl/qsfp_pkg.sv =====
`default_nettype none

package qsfp_pkg;

   localparam int DATA_W        = 32;  // element width
   localparam int IDX_W         = 5;   // element / stack index
   localparam int CNT_W         = 6;   // fill count, range size, stack depth
   localparam int MAX_ITEMS_DEF = 32;

   localparam logic KIND_PIVOT  = 1'b0;
   localparam logic KIND_SORTED = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_POP_W,
      ST_PIV_W,
      ST_J_RD,
      ST_J_CHK,
      ST_I_RD,
      ST_I_CHK,
      ST_SWAP,
      ST_PL_RD,
      ST_PL_MV,
      ST_PL_PIV,
      ST_PUSH_R,
      ST_PUSH_L,
      ST_O_RD,
      ST_O_W
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/quicksort_first_pivot_sorter_unit.sv =====
`default_nettype none

// channel | dir | handshake             | word
// --------+-----+-----------------------+--------------------------------------------
// req     | in  | req_valid / req_ready | req_value, req_is_last
// rsp     | out | rsp_valid / rsp_ready | rsp_kind, rsp_position, rsp_item_value,
//         |     |                       | rsp_final_res
//
// Loading takes one word per cycle; req_ready is high only while loading.
// The sort walks the element memory through its single read port: a compare reads
// a word and then checks it, a swap adds a state for its second write, and each
// range adds pop, pivot fetch, the closing index check, placement and the two
// pushes; ST_START seeds the stack and ST_POP finds it empty. Read-out reads each sorted word, then presents it.
// Reset (synchronous) clears the control state only; memories need no clearing.
// A stalled rsp side freezes the sequencer at the next pivot or sorted word.

module quicksort_first_pivot_sorter_unit
   import qsfp_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     req_is_last,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_kind,
   output logic [IDX_W-1:0]              rsp_position,
   output logic signed [DATA_W-1:0]      rsp_item_value,
   output logic                          rsp_final_res
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff,   cnt_in;    // words loaded so far
   logic [CNT_W-1:0]          n_ff,     n_in;      // words in this run
   logic [CNT_W-1:0]          depth_ff, depth_in;  // pending ranges
   logic [IDX_W-1:0]          lo_ff,    lo_in;
   logic [IDX_W-1:0]          hi_ff,    hi_in;
   logic [IDX_W-1:0]          i_ff,     i_in;
   logic [IDX_W-1:0]          j_ff,     j_in;
   logic [IDX_W-1:0]          p_ff,     p_in;      // read-out index
   logic signed [DATA_W-1:0]  piv_ff,   piv_in;
   logic signed [DATA_W-1:0]  tmp_ff,   tmp_in;    // swap holding word

   logic                      ovld_ff,  ovld_in;
   logic                      okind_ff, okind_in;
   logic [IDX_W-1:0]          opos_ff,  opos_in;
   logic signed [DATA_W-1:0]  oval_ff,  oval_in;
   logic                      ofin_ff,  ofin_in;

   // ---------------------------------------------------------------------
   // Memory ports
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0]  elem_mem [MAX_ITEMS];
   logic [2*IDX_W-1:0]        stk_mem  [MAX_ITEMS];

   logic                      mem_we, mem_re;
   logic [IDX_W-1:0]          mem_waddr, mem_raddr;
   logic signed [DATA_W-1:0]  mem_wdata;
   logic signed [DATA_W-1:0]  mem_rdata_ff;

   logic                      stk_we, stk_re;
   logic [IDX_W-1:0]          stk_waddr, stk_raddr;
   logic [2*IDX_W-1:0]        stk_wdata;
   logic [2*IDX_W-1:0]        stk_rdata_ff;

   logic                      out_free;
   logic                      rd_gt_piv;
   logic [CNT_W-1:0]          cnt_load;

   assign out_free  = !ovld_ff || rsp_ready;
   assign rd_gt_piv = mem_rdata_ff > piv_ff;
   assign cnt_load  = (cnt_ff < MAX_CNT) ? cnt_ff + CNT_W'(1) : cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         elem_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= elem_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stk_mem[stk_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      depth_in  = depth_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      piv_in    = piv_ff;
      tmp_in    = tmp_ff;

      ovld_in   = ovld_ff && !rsp_ready;
      okind_in  = okind_ff;
      opos_in   = opos_ff;
      oval_in   = oval_ff;
      ofin_in   = ofin_ff;

      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      stk_we    = 1'b0;
      stk_waddr = depth_ff[IDX_W-1:0];
      stk_wdata = '0;
      stk_re    = 1'b0;
      stk_raddr = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (cnt_ff < MAX_CNT) begin
                  mem_we    = 1'b1;
                  mem_waddr = cnt_ff[IDX_W-1:0];
                  mem_wdata = req_value;
               end
               cnt_in = cnt_load;
               if (req_is_last) begin
                  n_in     = cnt_load;
                  cnt_in   = '0;
                  state_in = ST_START;
               end
            end
         end

         ST_START: begin
            depth_in = '0;
            p_in     = '0;
            if (n_ff >= CNT_W'(2)) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = {IDX_W'(0), IDX_W'(n_ff - CNT_W'(1))};
               depth_in  = CNT_W'(1);
               state_in  = ST_POP;
            end else begin
               state_in = ST_O_RD;
            end
         end

         ST_POP: begin
            if (depth_ff == '0) begin
               p_in     = '0;
               state_in = ST_O_RD;
            end else begin
               stk_re    = 1'b1;
               stk_raddr = IDX_W'(depth_ff - CNT_W'(1));
               depth_in  = depth_ff - CNT_W'(1);
               state_in  = ST_POP_W;
            end
         end

         ST_POP_W: begin
            lo_in     = stk_rdata_ff[2*IDX_W-1:IDX_W];
            hi_in     = stk_rdata_ff[IDX_W-1:0];
            i_in      = stk_rdata_ff[2*IDX_W-1:IDX_W];
            j_in      = stk_rdata_ff[IDX_W-1:0];
            mem_re    = 1'b1;
            mem_raddr = stk_rdata_ff[2*IDX_W-1:IDX_W];
            state_in  = ST_PIV_W;
         end

         ST_PIV_W: begin
            piv_in   = mem_rdata_ff;
            state_in = ST_J_RD;
         end

         // right index walks down past words above the pivot
         ST_J_RD: begin
            if (i_ff == j_ff) begin
               state_in = ST_PL_RD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = j_ff;
               state_in  = ST_J_CHK;
            end
         end

         ST_J_CHK: begin
            if (rd_gt_piv) begin
               j_in     = j_ff - IDX_W'(1);
               state_in = ST_J_RD;
            end else begin
               tmp_in   = mem_rdata_ff;
               state_in = ST_I_RD;
            end
         end

         // left index walks up past words not above the pivot
         ST_I_RD: begin
            if (i_ff == j_ff) begin
               state_in = ST_PL_RD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = i_ff;
               state_in  = ST_I_CHK;
            end
         end

         ST_I_CHK: begin
            if (!rd_gt_piv) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_I_RD;
            end else begin
               // swap, first half: [i] <= old [j]
               mem_we    = 1'b1;
               mem_waddr = i_ff;
               mem_wdata = tmp_ff;
               tmp_in    = mem_rdata_ff;
               state_in  = ST_SWAP;
            end
         end

         ST_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = tmp_ff;
            state_in  = ST_J_RD;
         end

         // pivot placement: [lo] <= [i], [i] <= pivot
         ST_PL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff;
            state_in  = ST_PL_MV;
         end

         ST_PL_MV: begin
            mem_we    = 1'b1;
            mem_waddr = lo_ff;
            mem_wdata = mem_rdata_ff;
            state_in  = ST_PL_PIV;
         end

         ST_PL_PIV: begin
            if (out_free) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff;
               mem_wdata = piv_ff;
               ovld_in   = 1'b1;
               okind_in  = KIND_PIVOT;
               opos_in   = i_ff;
               oval_in   = piv_ff;
               ofin_in   = 1'b0;
               state_in  = ST_PUSH_R;
            end
         end

         // right part goes on first so the left part is taken next
         ST_PUSH_R: begin
            if (({1'b0, i_ff} + CNT_W'(1) < {1'b0, hi_ff}) && (depth_ff < MAX_CNT)) begin
               stk_we    = 1'b1;
               stk_wdata = {i_ff + IDX_W'(1), hi_ff};
               depth_in  = depth_ff + CNT_W'(1);
            end
            state_in = ST_PUSH_L;
         end

         ST_PUSH_L: begin
            if (({1'b0, lo_ff} + CNT_W'(1) < {1'b0, i_ff}) && (depth_ff < MAX_CNT)) begin
               stk_we    = 1'b1;
               stk_wdata = {lo_ff, i_ff - IDX_W'(1)};
               depth_in  = depth_ff + CNT_W'(1);
            end
            state_in = ST_POP;
         end

         ST_O_RD: begin
            mem_re    = 1'b1;
            mem_raddr = p_ff;
            state_in  = ST_O_W;
         end

         ST_O_W: begin
            if (out_free) begin
               ovld_in  = 1'b1;
               okind_in = KIND_SORTED;
               opos_in  = p_ff;
               oval_in  = mem_rdata_ff;
               ofin_in  = ({1'b0, p_ff} == n_ff - CNT_W'(1));
               if ({1'b0, p_ff} == n_ff - CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  p_in     = p_ff + IDX_W'(1);
                  state_in = ST_O_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         depth_ff <= '0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         depth_ff <= depth_in;
         ovld_ff  <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      p_ff     <= p_in;
      piv_ff   <= piv_in;
      tmp_ff   <= tmp_in;
      okind_ff <= okind_in;
      opos_ff  <= opos_in;
      oval_ff  <= oval_in;
      ofin_ff  <= ofin_in;
   end

   assign rsp_valid      = ovld_ff;
   assign rsp_kind       = okind_ff;
   assign rsp_position   = opos_ff;
   assign rsp_item_value = oval_ff;
   assign rsp_final_res  = ofin_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("load count above capacity");

   // pending ranges are disjoint and hold two or more words each
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= MAX_CNT / CNT_W'(2))
      else $error("range stack deeper than possible");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_J_RD || state_ff == ST_J_CHK || state_ff == ST_I_RD ||
       state_ff == ST_I_CHK || state_ff == ST_SWAP) |->
      (lo_ff <= i_ff && i_ff <= j_ff && j_ff <= hi_ff))
      else $error("partition indices out of order");

   a_final_sorted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_res) |-> (rsp_kind == KIND_SORTED))
      else $error("final flag on a pivot word");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_O_W && out_free && ({1'b0, p_ff} == n_ff - CNT_W'(1))) |=>
      (state_ff == ST_IDLE && rsp_final_res && cnt_ff == '0))
      else $error("run did not close on its last sorted word");

endmodule

`default_nettype wire
